// ----- hw/rtl/rpc_pkg.sv -----
// Shared types and constants for the radius point clustering block.
// No dependencies.
`default_nettype none
package rpc_pkg;
  localparam int unsigned MaxPointsDef = 4096;
  localparam int unsigned CoordW = 11;
  localparam int unsigned LabelW = 13;
  localparam logic [LabelW-1:0] IdMax = 13'd8191;

  localparam logic [1:0] OpLoad  = 2'd0;
  localparam logic [1:0] OpRun   = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;
  localparam logic [1:0] OpClear = 2'd3;

  // controller -> datapath commands
  typedef struct packed {
    logic load;        // write point at count
    logic clear;       // zero count and kept clusters
    logic run_start;   // reset run indexes, capture radius squared
    logic vis_clr;     // clear visited entry at scan index
    logic seed_rd;     // read visited of seed
    logic seed_take;   // start cluster with seed
    logic mem_rd;      // pop queue head, read member index
    logic mem_pt;      // read member coords
    logic mem_lat;     // latch member coords
    logic cand_rd;     // read candidate j
    logic cand_eval;   // evaluate candidate
    logic lab_rd;      // read queue entry for labeling
    logic lab_wr;      // write label
    logic fin_cl;      // decide cluster id
    logic run_done;    // commit kept clusters
    logic lab_clr;     // zero the label result
    logic rd_lat;      // latch label result
  } rpc_cmd_t;

  typedef struct packed {
    logic seed_end;    // seed index reached count
    logic seed_vis;    // seed visited
    logic queue_empty; // head == tail
    logic cand_end;    // candidate index reached count
    logic lab_end;     // labeling index reached tail
    logic scan_end;    // visited clear sweep done
  } rpc_sts_t;
endpackage
`default_nettype wire

// ----- hw/rtl/rpc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module rpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/rpc_datapath.sv -----
// Datapath: point, visited, queue and label memories, indexes, distance test.
// Depends on rpc_pkg and rpc_ram.
`default_nettype none
module rpc_datapath #(
  parameter int unsigned MaxPoints = rpc_pkg::MaxPointsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rpc_pkg::rpc_cmd_t             cmd_i,
  output rpc_pkg::rpc_sts_t                  sts_o,
  input  wire logic                          seed_inc_i,
  input  wire logic [rpc_pkg::CoordW-1:0]    x_i,
  input  wire logic [rpc_pkg::CoordW-1:0]    y_i,
  input  wire logic [11:0]                   idx_i,
  input  wire logic [rpc_pkg::CoordW-1:0]    radius_i,
  input  wire logic [rpc_pkg::LabelW-1:0]    min_size_i,
  output logic                               load_err_o,
  output logic                               read_err_o,
  output logic [rpc_pkg::LabelW-1:0]         label_o,
  output logic [rpc_pkg::LabelW-1:0]         kept_o
);
  import rpc_pkg::*;
  localparam int unsigned AW = $clog2(MaxPoints);
  localparam int unsigned CW = $clog2(MaxPoints + 1);
  localparam int unsigned SqW = 2*CoordW + 2;
  localparam logic [CW-1:0] MaxCnt = CW'(MaxPoints);

  logic [CW-1:0] count_q;
  logic [CW-1:0] seed_q, cand_q, head_q, tail_q, lab_q, scan_q;
  logic [LabelW-1:0] kept_q, run_kept_q, id_q;
  logic [CoordW-1:0] mx_q, my_q;
  logic [LabelW-1:0] label_q;
  logic [SqW-1:0] lim_q;
  logic [SqW-1:0] rad_w;

  // memories
  logic [AW-1:0] pt_raddr;
  logic [CoordW-1:0] px_rd, py_rd;
  logic vis_we, vis_wd, vis_rd;
  logic [AW-1:0] vis_waddr, vis_raddr;
  logic q_we;
  logic [AW-1:0] q_waddr, q_raddr, q_rd;
  logic [AW-1:0] lab_waddr, lab_raddr;
  logic [LabelW-1:0] lab_rd;

  rpc_ram #(.Width(CoordW), .Depth(MaxPoints)) u_xram (
    .clk_i, .we_i(cmd_i.load), .waddr_i(count_q[AW-1:0]), .wdata_i(x_i),
    .raddr_i(pt_raddr), .rdata_o(px_rd));
  rpc_ram #(.Width(CoordW), .Depth(MaxPoints)) u_yram (
    .clk_i, .we_i(cmd_i.load), .waddr_i(count_q[AW-1:0]), .wdata_i(y_i),
    .raddr_i(pt_raddr), .rdata_o(py_rd));
  rpc_ram #(.Width(1), .Depth(MaxPoints)) u_vram (
    .clk_i, .we_i(vis_we), .waddr_i(vis_waddr), .wdata_i(vis_wd),
    .raddr_i(vis_raddr), .rdata_o(vis_rd));
  rpc_ram #(.Width(AW), .Depth(MaxPoints)) u_qram (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(cmd_i.seed_take ?
    seed_q[AW-1:0] : cand_q[AW-1:0]), .raddr_i(q_raddr), .rdata_o(q_rd));
  rpc_ram #(.Width(LabelW), .Depth(MaxPoints)) u_lram (
    .clk_i, .we_i(cmd_i.lab_wr), .waddr_i(lab_waddr), .wdata_i(id_q),
    .raddr_i(lab_raddr), .rdata_o(lab_rd));

  // distance test on candidate coords just read
  logic [CoordW-1:0] dx, dy;
  logic [SqW-1:0] dx_w, dy_w, dsq;
  logic close;
  always_comb begin
    dx = (px_rd > mx_q) ? px_rd - mx_q : mx_q - px_rd;
    dy = (py_rd > my_q) ? py_rd - my_q : my_q - py_rd;
    dx_w = SqW'(dx);
    dy_w = SqW'(dy);
    dsq = dx_w * dx_w + dy_w * dy_w;
    close = !vis_rd && (dsq < lim_q);
  end
  assign rad_w = SqW'(radius_i);

  always_comb begin
    pt_raddr = cmd_i.mem_pt ? q_rd : cand_q[AW-1:0];
    vis_raddr = cmd_i.seed_rd ? seed_q[AW-1:0] : cand_q[AW-1:0];
    vis_we = cmd_i.vis_clr || cmd_i.seed_take || (cmd_i.cand_eval && close);
    vis_wd = !cmd_i.vis_clr;
    vis_waddr = cmd_i.vis_clr ? scan_q[AW-1:0] :
                cmd_i.seed_take ? seed_q[AW-1:0] : cand_q[AW-1:0];
    q_we = cmd_i.seed_take || (cmd_i.cand_eval && close && tail_q < MaxCnt);
    q_waddr = cmd_i.seed_take ? '0 : tail_q[AW-1:0];
    q_raddr = cmd_i.lab_rd ? lab_q[AW-1:0] : head_q[AW-1:0];
    lab_waddr = q_rd;
    lab_raddr = AW'(idx_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      kept_q <= '0;
      run_kept_q <= '0;
      seed_q <= '0; cand_q <= '0; head_q <= '0; tail_q <= '0;
      lab_q <= '0; scan_q <= '0; id_q <= '0; lim_q <= '0;
      label_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
        kept_q <= '0;
      end else if (cmd_i.load && count_q < MaxCnt) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.run_start) begin
        run_kept_q <= '0;
        scan_q <= '0;
        seed_q <= '0;
        lim_q <= rad_w * rad_w;
      end else begin
        if (cmd_i.vis_clr) scan_q <= scan_q + 1'b1;
        if (seed_inc_i) seed_q <= seed_q + 1'b1;
      end
      if (cmd_i.run_done) begin
        kept_q <= run_kept_q;
      end
      if (cmd_i.seed_take) begin
        head_q <= '0;
        tail_q <= CW'(1);
        cand_q <= seed_q + 1'b1;
      end else if (cmd_i.mem_rd) begin
        head_q <= head_q + 1'b1;
        cand_q <= seed_q + 1'b1;
      end else if (cmd_i.cand_eval) begin
        cand_q <= cand_q + 1'b1;
        if (close && tail_q < MaxCnt) tail_q <= tail_q + 1'b1;
      end
      if (cmd_i.fin_cl) begin
        lab_q <= '0;
        if (32'(tail_q) > 32'(min_size_i)) begin
          if (run_kept_q < IdMax) begin
            run_kept_q <= run_kept_q + 1'b1;
            id_q <= run_kept_q + 1'b1;
          end else begin
            id_q <= run_kept_q;
          end
        end else begin
          id_q <= '0;
        end
      end else if (cmd_i.lab_rd) begin
        lab_q <= lab_q + 1'b1;
      end
      if (cmd_i.rd_lat) label_q <= lab_rd;
      else if (cmd_i.lab_clr) label_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_lat) begin
      mx_q <= px_rd;
      my_q <= py_rd;
    end
  end

  assign sts_o.seed_end = (seed_q >= count_q);
  assign sts_o.seed_vis = vis_rd;
  assign sts_o.queue_empty = (head_q == tail_q);
  assign sts_o.cand_end = (cand_q >= count_q);
  assign sts_o.lab_end = (lab_q == tail_q);
  assign sts_o.scan_end = (scan_q == MaxCnt - 1'b1);
  assign load_err_o = (count_q >= MaxCnt);
  assign read_err_o = (32'(idx_i) >= 32'(count_q)) || (32'(idx_i) >= MaxPoints);
  assign label_o = label_q;
  assign kept_o = kept_q;
endmodule
`default_nettype wire

// ----- hw/rtl/rpc_ctrl.sv -----
// Controller state machine for the clustering run and the load, clear and read ops.
// Depends on rpc_pkg.
`default_nettype none
module rpc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        op_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   err_o,
  input  wire logic              load_err_i,
  input  wire logic              read_err_i,
  output rpc_pkg::rpc_cmd_t      cmd_o,
  input  wire rpc_pkg::rpc_sts_t sts_i,
  output logic                   seed_inc_o
);
  import rpc_pkg::*;
  localparam logic [3:0] SIdle = 4'd0, SClr = 4'd1, SSeedRd = 4'd2,
    SSeedChk = 4'd3, SMemRd = 4'd4, SMemLat = 4'd5, SCandRd = 4'd6,
    SCandEv = 4'd7, SFin = 4'd8, SLabRd = 4'd9, SLabWr = 4'd10,
    SReadLat = 4'd11, SOut = 4'd12, SMemPt = 4'd13;
  logic [3:0] state_q, state_d;
  logic err_q, err_d, ov_q, ov_d;
  logic accept;

  assign in_ready_o = (state_q == SIdle) && (!ov_q || out_ready_i);
  assign accept = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign err_o = err_q;

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    err_d = err_q;
    ov_d = ov_q && !out_ready_i;
    seed_inc_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (accept) begin
          cmd_o.lab_clr = 1'b1;
          unique case (op_i)
            OpLoad: begin
              cmd_o.load = !load_err_i;
              err_d = load_err_i;
              ov_d = 1'b1;
            end
            OpClear: begin
              cmd_o.clear = 1'b1;
              err_d = 1'b0;
              ov_d = 1'b1;
            end
            OpRead: begin
              err_d = read_err_i;
              state_d = SReadLat;
            end
            default: begin
              cmd_o.run_start = 1'b1;
              state_d = SClr;
            end
          endcase
        end
      end
      SReadLat: begin
        // label of an erring read stays zero
        cmd_o.rd_lat = !err_q;
        ov_d = 1'b1;
        state_d = SIdle;
      end
      SClr: begin
        cmd_o.vis_clr = 1'b1;
        if (sts_i.scan_end) state_d = SSeedRd;
      end
      SSeedRd: begin
        if (sts_i.seed_end) begin
          cmd_o.run_done = 1'b1;
          err_d = 1'b0;
          state_d = SOut;
        end else begin
          cmd_o.seed_rd = 1'b1;
          state_d = SSeedChk;
        end
      end
      SSeedChk: begin
        if (sts_i.seed_vis) begin
          seed_inc_o = 1'b1;
          state_d = SSeedRd;
        end else begin
          cmd_o.seed_take = 1'b1;
          state_d = SMemRd;
        end
      end
      SMemRd: begin
        if (sts_i.queue_empty) begin
          cmd_o.fin_cl = 1'b1;
          state_d = SFin;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d = SMemPt;
        end
      end
      SMemPt: begin
        cmd_o.mem_pt = 1'b1;
        state_d = SMemLat;
      end
      SMemLat: begin
        cmd_o.mem_lat = 1'b1;
        state_d = SCandRd;
      end
      SCandRd: begin
        if (sts_i.cand_end) state_d = SMemRd;
        else begin
          cmd_o.cand_rd = 1'b1;
          state_d = SCandEv;
        end
      end
      SCandEv: begin
        cmd_o.cand_eval = 1'b1;
        state_d = SCandRd;
      end
      SFin: state_d = SLabRd;
      SLabRd: begin
        if (sts_i.lab_end) begin
          seed_inc_o = 1'b1;
          state_d = SSeedRd;
        end else begin
          cmd_o.lab_rd = 1'b1;
          state_d = SLabWr;
        end
      end
      SLabWr: begin
        cmd_o.lab_wr = 1'b1;
        state_d = SLabRd;
      end
      SOut: begin
        ov_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      err_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      err_q <= err_d;
      ov_q <= ov_d;
    end
  end

  // a seed index only advances while no cluster is being built
  a_seed_inc_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_inc_o |-> (state_q == SSeedChk || state_q == SLabRd))
    else $error("seed advance outside seed or label phase");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> !in_ready_o)
    else $error("input ready while busy");
  a_eval_follows_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cand_eval |-> $past(cmd_o.cand_rd))
    else $error("candidate evaluated without read");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");
endmodule
`default_nettype wire

// ----- hw/rtl/radius_point_clustering.sv -----
// Radius point clustering: top level with APB register port and item channels.
// Depends on rpc_pkg, rpc_ctrl, rpc_datapath.
// Loads and clears take one item per cycle while the output is not stalled; a
// label read is accepted, then latched from the label memory. A run first
// sweeps the visited memory, then walks the stored points: each seed is
// checked against the visited memory, and for each cluster member every later
// point is read over the single point-memory read port and tested, then the
// members are labelled. Input is stalled for the whole run; every result waits
// in the output register, which holds off input until it is taken.
`default_nettype none
module radius_point_clustering #(
  parameter int unsigned MaxPoints = rpc_pkg::MaxPointsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [10:0] x_coord_i,
  input  wire logic [10:0] y_coord_i,
  input  wire logic [11:0] point_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [12:0]      label_o,
  output logic [12:0]      cluster_count_o,
  output logic             error_o
);
  import rpc_pkg::*;
  localparam logic [2:0] AddrRadius = 3'd0, AddrMinSize = 3'd4;
  logic [10:0] radius_q;
  logic [12:0] min_size_q;
  rpc_cmd_t cmd;
  rpc_sts_t sts;
  logic load_err, read_err, seed_inc;
  logic [12:0] kept;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 11'd20;
      min_size_q <= 13'd100;
    end else if (psel && penable && pwrite) begin
      if (paddr == AddrRadius) radius_q <= pwdata[10:0];
      else if (paddr == AddrMinSize) min_size_q <= pwdata[12:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == AddrRadius) prdata = {21'd0, radius_q};
    else if (paddr == AddrMinSize) prdata = {19'd0, min_size_q};
  end

  rpc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i(operation_i),
    .out_valid_o, .out_ready_i, .err_o(error_o), .load_err_i(load_err),
    .read_err_i(read_err), .cmd_o(cmd), .sts_i(sts), .seed_inc_o(seed_inc));

  rpc_datapath #(.MaxPoints(MaxPoints)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .seed_inc_i(seed_inc),
    .x_i(x_coord_i), .y_i(y_coord_i), .idx_i(point_index_i),
    .radius_i(radius_q), .min_size_i(min_size_q), .load_err_o(load_err),
    .read_err_o(read_err), .label_o(label_o), .kept_o(kept));

  assign cluster_count_o = kept;
endmodule
`default_nettype wire

// ----- dv/radius_point_clustering_tb.sv -----
// Testbench for radius_point_clustering: a scoreboard class predicts every
// result from its own copy of the point set, and plain tasks drive the block.
// Depends on rpc_pkg and the RTL of radius_point_clustering.
module radius_point_clustering_tb;
  import rpc_pkg::*;

  localparam int unsigned NPts      = 4096;
  localparam int unsigned WdogLimit = 400000;
  localparam int unsigned RandItems = 1850;
  localparam logic [2:0]  AddrRadius  = 3'd0;
  localparam logic [2:0]  AddrMinSize = 3'd4;

  typedef struct packed {
    logic [12:0] label;
    logic [12:0] count;
    logic        err;
  } cluster_result_t;

  class cluster_scoreboard;
    logic [10:0]     xs [NPts];
    logic [10:0]     ys [NPts];
    logic [12:0]     labels [NPts];
    bit              labeled [NPts];
    int unsigned     npts;
    int unsigned     kept;
    int unsigned     radius;
    int unsigned     min_size;
    cluster_result_t pending_q[$];
    int              errors;

    function new();
      radius   = 20;
      min_size = 100;
      npts     = 0;
      kept     = 0;
      errors   = 0;
      foreach (labeled[i]) labeled[i] = 0;
    endfunction

    function void set_reg(logic [2:0] addr, logic [31:0] value);
      if (addr == AddrRadius) radius = 32'(value[10:0]);
      else if (addr == AddrMinSize) min_size = 32'(value[12:0]);
    endfunction

    function int unsigned sq_dist(int unsigned a, int unsigned b);
      int unsigned dx;
      int unsigned dy;
      dx = (xs[a] > xs[b]) ? 32'(xs[a]) - 32'(xs[b]) : 32'(xs[b]) - 32'(xs[a]);
      dy = (ys[a] > ys[b]) ? 32'(ys[a]) - 32'(ys[b]) : 32'(ys[b]) - 32'(ys[a]);
      return dx * dx + dy * dy;
    endfunction

    // breadth-first grouping in load order; candidates only above the seed
    function void group_points();
      bit          vis [NPts];
      int unsigned members [NPts];
      int unsigned lim;
      int unsigned head;
      int unsigned tail;
      int unsigned m;
      int unsigned id;
      lim  = radius * radius;
      kept = 0;
      foreach (vis[i]) vis[i] = 0;
      for (int unsigned p = 0; p < npts; p++) begin
        if (vis[p]) continue;
        vis[p] = 1;
        head = 0;
        tail = 0;
        members[tail++] = p;
        while (head < tail) begin
          m = members[head++];
          for (int unsigned j = p + 1; j < npts; j++) begin
            if (!vis[j] && sq_dist(m, j) < lim) begin
              vis[j] = 1;
              members[tail++] = j;
            end
          end
        end
        id = 0;
        if (tail > min_size) begin
          if (kept < IdMax) kept++;
          id = kept;
        end
        for (int unsigned k = 0; k < tail; k++) begin
          labels[members[k]]  = 13'(id);
          labeled[members[k]] = 1;
        end
      end
    endfunction

    function void note_input(logic [1:0] op, logic [10:0] x, logic [10:0] y,
                             logic [11:0] idx);
      cluster_result_t r;
      r = '0;
      case (op)
        OpLoad: begin
          if (npts >= NPts) r.err = 1;
          else begin
            xs[npts] = x;
            ys[npts] = y;
            npts++;
          end
        end
        OpRun: group_points();
        OpRead: begin
          if (idx >= npts) r.err = 1;
          else r.label = labels[idx];
        end
        default: begin
          npts = 0;
          kept = 0;
        end
      endcase
      r.count = 13'(kept);
      pending_q = {pending_q, r};
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [12:0] label, logic [12:0] count, logic err);
      cluster_result_t e;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending (label %0d)", label));
      end else begin
        e = pending_q.pop_front();
        if (label !== e.label)
          report_mismatch($sformatf("label %0d, want %0d", label, e.label));
        if (count !== e.count)
          report_mismatch($sformatf("cluster_count %0d, want %0d", count, e.count));
        if (err !== e.err)
          report_mismatch($sformatf("error %0b, want %0b", err, e.err));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  operation_i;
  logic [10:0] x_coord_i;
  logic [10:0] y_coord_i;
  logic [11:0] point_index_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [12:0] label_o;
  logic [12:0] cluster_count_o;
  logic        error_o;

  cluster_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cycles;
  int unsigned sent_items;
  int unsigned idle_count;

  radius_point_clustering u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .x_coord_i      (x_coord_i),
    .y_coord_i      (y_coord_i),
    .point_index_i  (point_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .label_o        (label_o),
    .cluster_count_o(cluster_count_o),
    .error_o        (error_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    sent_items     = 0;
    idle_count     = 0;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    operation_i    = OpLoad;
    x_coord_i      = '0;
    y_coord_i      = '0;
    point_index_i  = '0;
    out_ready_i    = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // result side
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(label_o, cluster_count_o, error_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WdogLimit) begin
        $display("watchdog: no transfer for %0d cycles", WdogLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task send_item(logic [1:0] op, logic [10:0] x, logic [10:0] y, logic [11:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    x_coord_i     <= x;
    y_coord_i     <= y;
    point_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(op, x, y, idx);
    sent_items++;
  endtask

  task send_load(int unsigned x, int unsigned y);
    send_item(OpLoad, 11'(x), 11'(y), 12'($urandom_range(0, 4095)));
  endtask

  task send_op(logic [1:0] op);
    send_item(op, 11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
              12'($urandom_range(0, 4095)));
  endtask

  task send_read(int unsigned idx);
    send_item(OpRead, 11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
              12'(idx));
  endtask

  // every result in hand, block idle
  task drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_reg(addr, data);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task set_config(int unsigned rad, int unsigned msz);
    drain();
    apb_write(AddrRadius, rad);
    apb_write(AddrMinSize, msz);
  endtask

  // index some run has labeled, else out of range, or a clear if the set is full
  task read_some();
    int unsigned idx;
    bit found;
    found = 0;
    if (sb.npts > 0 && $urandom_range(0, 4) != 0) begin
      for (int t = 0; t < 20 && !found; t++) begin
        idx = $urandom_range(0, sb.npts - 1);
        found = sb.labeled[idx];
      end
    end
    if (found) send_read(idx);
    else if (sb.npts < NPts) send_read($urandom_range(sb.npts, 4095));
    else send_op(OpClear);
  endtask

  function int unsigned clamp_coord(int c);
    return (c < 0) ? 0 : (c > 2047) ? 2047 : unsigned'(c);
  endfunction

  task random_phase(int unsigned phase);
    int unsigned rad;
    int unsigned msz;
    int unsigned npts;
    int unsigned spread;
    int          cx [4];
    int          cy [4];
    int unsigned c;
    case ($urandom_range(0, 7))
      0: rad = 1;
      1: rad = 2047;
      default: rad = $urandom_range(2, 200);
    endcase
    case ($urandom_range(0, 7))
      0: msz = 4096;
      1: msz = 0;
      default: msz = $urandom_range(0, 6);
    endcase
    set_config(rad, msz);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
      default: begin send_idle_pct = 8; recv_stall_pct = 8; end
    endcase
    if (phase == 6) begin
      // long hold-off with a steady sender: the block fills and stalls input
      send_idle_pct = 0;
      hold_cycles   = 400;
    end
    if ($urandom_range(0, 3) != 0) send_op(OpClear);
    npts   = (phase == 9) ? 150 : $urandom_range(1, 40);
    spread = $urandom_range(0, rad + 2);
    foreach (cx[i]) begin
      cx[i] = int'($urandom_range(0, 2047));
      cy[i] = int'($urandom_range(0, 2047));
    end
    for (int unsigned k = 0; k < npts; k++) begin
      if (sb.npts >= 200) break;
      c = $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) send_load($urandom_range(0, 2047), $urandom_range(0, 2047));
      else send_load(
        clamp_coord(cx[c] + int'($urandom_range(0, 2 * spread)) - int'(spread)),
        clamp_coord(cy[c] + int'($urandom_range(0, 2 * spread)) - int'(spread)));
      if ($urandom_range(0, 9) == 0) read_some();
    end
    send_op(OpRun);
    repeat ($urandom_range(4, 16)) read_some();
    if ($urandom_range(0, 5) == 0) begin
      send_op(OpClear);
      send_op(OpRun);
      read_some();
    end
  endtask

  initial begin
    int unsigned phase;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // directed: empty set, corner coordinates, register extremes
    send_read(0);
    send_op(OpRun);
    send_item(OpLoad, 11'd0, 11'd0, 12'hfff);
    send_item(OpLoad, 11'h7ff, 11'h7ff, 12'd0);
    send_item(OpLoad, 11'd0, 11'h7ff, 12'hfff);
    send_item(OpLoad, 11'h7ff, 11'd0, 12'd0);
    send_load(5, 5);
    send_load(6, 6);
    send_op(OpRun);
    send_read(5);
    set_config(0, 0);  // nothing is close: every point stands alone
    send_op(OpRun);
    for (int i = 0; i < 6; i++) send_read(i);
    set_config(2047, 4096);
    send_op(OpRun);
    send_read(0);
    send_read(4095);
    set_config(2047, 0);
    send_op(OpRun);
    send_read(3);
    send_op(OpClear);
    send_read(0);      // stale label, but count is zero now
    send_op(OpRun);
    send_load(100, 100);
    send_read(0);      // stale label from an earlier run

    set_config(20, 100);
    send_op(OpClear);

    phase = 0;
    while (sent_items < RandItems) begin
      random_phase(phase);
      phase++;
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
